@@ rtl/core/uartrx_pkg.sv @@
// uartrx_pkg: constants shared by the uart receiver with start timeout
// field widths, receiver phase codes and configuration register indexes
// no dependencies
package uartrx_pkg;

    localparam int BP_W      = 16;
    localparam int LIMIT_W   = 31;
    localparam int ELAPSED_W = 20;
    localparam int DATA_W    = 8;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 31;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_EDGE = 2'd1;
    localparam logic [1:0] PH_RECV = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_BIT_PERIOD    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_LIMIT = 1'd1;

    localparam logic [BP_W-1:0]    BIT_PERIOD_RST    = 16'd104;
    localparam logic [LIMIT_W-1:0] TIMEOUT_LIMIT_RST = 31'h7fff_f000;
    localparam logic [LIMIT_W-1:0] IDLE_MAX          = 31'h7fff_ffff;

    typedef logic [1:0] phase_t;

endpackage

@@ rtl/core/uart_receiver_with_start_timeout_unit.sv @@
// uart_receiver_with_start_timeout_unit: 8n1-style serial receiver with start edge timeout
// one line sample per beat; result beat is a byte or a timeout flag
// depends on uartrx_pkg
// a result beat is presented in the cycle after the line beat that completes it
// throughput: one line beat per cycle; the output register frees input ready
//   whenever it is empty or being drained in the same cycle
// reset: asynchronous, active low; receiver waits for an idle-high line,
//   bit_period returns to 104 and timeout_limit to 0x7ffff000
module uart_receiver_with_start_timeout_unit #(
    parameter int DATA_BITS = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_en,
    input  logic [uartrx_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [uartrx_pkg::CFG_W-1:0]         cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 line,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [uartrx_pkg::DATA_W-1:0]        data,
    output logic                                 timed_out
);

    localparam int BPW   = uartrx_pkg::BP_W;
    localparam int LW    = uartrx_pkg::LIMIT_W;
    localparam int EW    = uartrx_pkg::ELAPSED_W;
    localparam int DW    = uartrx_pkg::DATA_W;
    localparam int CNT_W = $clog2(DATA_BITS + 1);
    localparam int TGT_W = CNT_W + BPW + 1;

    // configuration
    logic [BPW-1:0] bit_period_reg;
    logic [LW-1:0]  timeout_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_period_reg    <= uartrx_pkg::BIT_PERIOD_RST;
            timeout_limit_reg <= uartrx_pkg::TIMEOUT_LIMIT_RST;
        end
        else if (cfg_en)
        begin
            case (cfg_index)
                uartrx_pkg::REG_BIT_PERIOD:    bit_period_reg    <= cfg_data[BPW-1:0];
                uartrx_pkg::REG_TIMEOUT_LIMIT: timeout_limit_reg <= cfg_data[LW-1:0];
                default: ;
            endcase
        end
    end

    // receiver state
    uartrx_pkg::phase_t     phase_reg, phase_next;
    logic [EW-1:0]          elapsed_reg, elapsed_next;
    logic [CNT_W-1:0]       bits_reg, bits_next;
    logic [DATA_BITS-1:0]   rx_reg, rx_next;
    logic [LW-1:0]          idle_reg, idle_next;

    logic                   out_valid_reg, out_valid_next;
    logic [DW-1:0]          data_reg, data_next;
    logic                   timed_out_reg, timed_out_next;

    logic                   accept;
    logic                   emit;
    logic [LW-1:0]          idle_inc;
    logic [EW-1:0]          elapsed_inc;
    logic [CNT_W-1:0]       bits_inc;
    logic [TGT_W-1:0]       target;
    logic [DATA_BITS-1:0]   rx_shift;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign idle_inc    = (idle_reg == uartrx_pkg::IDLE_MAX) ? idle_reg : idle_reg + 1'b1;
    assign elapsed_inc = elapsed_reg + 1'b1;
    assign bits_inc    = bits_reg + 1'b1;
    assign target      = TGT_W'(bit_period_reg >> 1) + TGT_W'(bits_inc) * TGT_W'(bit_period_reg);
    assign rx_shift    = {line, rx_reg[DATA_BITS-1:1]};

    always_comb
    begin
        phase_next     = phase_reg;
        elapsed_next   = elapsed_reg;
        bits_next      = bits_reg;
        rx_next        = rx_reg;
        idle_next      = idle_reg;
        emit           = 1'b0;
        data_next      = data_reg;
        timed_out_next = timed_out_reg;
        if (accept)
        begin
            case (phase_reg)
                uartrx_pkg::PH_EDGE:
                begin
                    if (line)
                    begin
                        if (idle_inc > timeout_limit_reg)
                        begin
                            phase_next     = uartrx_pkg::PH_IDLE;
                            idle_next      = '0;
                            emit           = 1'b1;
                            data_next      = '0;
                            timed_out_next = 1'b1;
                        end
                        else
                        begin
                            idle_next = idle_inc;
                        end
                    end
                    else
                    begin
                        phase_next   = uartrx_pkg::PH_RECV;
                        elapsed_next = '0;
                        bits_next    = '0;
                        rx_next      = '0;
                    end
                end
                uartrx_pkg::PH_RECV:
                begin
                    elapsed_next = elapsed_inc;
                    if (TGT_W'(elapsed_inc) >= target)
                    begin
                        if (bits_inc >= CNT_W'(DATA_BITS))
                        begin
                            phase_next     = uartrx_pkg::PH_IDLE;
                            elapsed_next   = '0;
                            bits_next      = '0;
                            rx_next        = '0;
                            emit           = 1'b1;
                            data_next      = DW'(rx_shift);
                            timed_out_next = 1'b0;
                        end
                        else
                        begin
                            bits_next = bits_inc;
                            rx_next   = rx_shift;
                        end
                    end
                end
                default:
                begin
                    // unused code behaves as wait-idle
                    phase_next = uartrx_pkg::PH_IDLE;
                    if (line)
                    begin
                        phase_next = uartrx_pkg::PH_EDGE;
                        idle_next  = '0;
                    end
                end
            endcase
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= uartrx_pkg::PH_IDLE;
            elapsed_reg   <= '0;
            bits_reg      <= '0;
            rx_reg        <= '0;
            idle_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            elapsed_reg   <= elapsed_next;
            bits_reg      <= bits_next;
            rx_reg        <= rx_next;
            idle_reg      <= idle_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg      <= data_next;
        timed_out_reg <= timed_out_next;
    end

    assign out_valid = out_valid_reg;
    assign data      = data_reg;
    assign timed_out = timed_out_reg;

    // checks
    a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != 2'd3)
        else $error("receiver phase left its legal codes");

    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == uartrx_pkg::PH_IDLE |-> (bits_reg == '0 && rx_reg == '0 && elapsed_reg == '0))
        else $error("receive state not cleared in wait-idle");

    a_bits_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bits_reg < CNT_W'(DATA_BITS))
        else $error("bit count reached data width without a result");

    a_timeout_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && timed_out |-> data == '0)
        else $error("timeout beat carries data");

    a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(accept))
        else $error("result beat without an accepted line beat");

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// testbench: self-checking bench for uart_receiver_with_start_timeout_unit
// predicts decoded bytes and start-edge timeouts from the sampled line, one beat per tick
// depends on uartrx_pkg and the receiver unit
module testbench;

    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int unsigned HOLD_LONG   = 250;

    typedef struct packed {
        logic [uartrx_pkg::DATA_W-1:0] data;
        logic                          timed_out;
    } rx_result_t;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_COIN,
        READY_SPARSE,
        READY_PATTERN
    } ready_mode_e;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             cfg_en = 1'b0;
    logic [uartrx_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [uartrx_pkg::CFG_W-1:0]     cfg_data = '0;
    logic                             in_valid = 1'b0;
    logic                             in_ready;
    logic                             line = 1'b1;
    logic                             out_valid;
    logic                             out_ready = 1'b0;
    logic [uartrx_pkg::DATA_W-1:0]    data;
    logic                             timed_out;

    // receiver state as the checker sees it
    logic [uartrx_pkg::BP_W-1:0]      cfg_period;
    logic [uartrx_pkg::LIMIT_W-1:0]   cfg_limit;
    uartrx_pkg::phase_t               rx_phase;
    logic [uartrx_pkg::ELAPSED_W-1:0] ticks_since_edge;
    logic [3:0]                       bit_count;
    logic [uartrx_pkg::DATA_W-1:0]    shift_byte;
    logic [uartrx_pkg::LIMIT_W-1:0]   high_count;

    rx_result_t           expected_rx[$];
    rx_result_t           want_rx;
    int unsigned          errors = 0;
    int unsigned          rx_count = 0;
    int unsigned          ticks_sent = 0;
    int unsigned          cycles = 0;

    int unsigned          gap_max = 3;
    int unsigned          burst_max = 12;
    int unsigned          burst_left = 0;

    int unsigned          hold_cycles = 0;
    ready_mode_e          ready_mode = READY_ALWAYS;
    int unsigned          mode_left = 0;
    logic [2:0]           pattern_count = '0;

    uart_receiver_with_start_timeout_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_en    (cfg_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .line      (line),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .data      (data),
        .timed_out (timed_out)
    );

    always #10 clk = ~clk;

    function void reset_receiver_model();
        cfg_period       = uartrx_pkg::BIT_PERIOD_RST;
        cfg_limit        = uartrx_pkg::TIMEOUT_LIMIT_RST;
        rx_phase         = uartrx_pkg::PH_IDLE;
        ticks_since_edge = '0;
        bit_count        = '0;
        shift_byte       = '0;
        high_count       = '0;
    endfunction

    function void predict_tick(input logic level);
        logic [31:0] target;
        rx_result_t  res;
        case (rx_phase)
            uartrx_pkg::PH_EDGE:
            begin
                if (level)
                begin
                    if (high_count != uartrx_pkg::IDLE_MAX)
                        high_count = high_count + 1'b1;
                    if (high_count > cfg_limit)
                    begin
                        rx_phase   = uartrx_pkg::PH_IDLE;
                        high_count = '0;
                        res.data      = '0;
                        res.timed_out = 1'b1;
                        expected_rx.push_back(res);
                    end
                end
                else
                begin
                    rx_phase         = uartrx_pkg::PH_RECV;
                    ticks_since_edge = '0;
                    bit_count        = '0;
                    shift_byte       = '0;
                end
            end
            uartrx_pkg::PH_RECV:
            begin
                ticks_since_edge = ticks_since_edge + 1'b1;
                target = {17'b0, cfg_period[uartrx_pkg::BP_W-1:1]}
                       + ({28'b0, bit_count} + 32'd1) * {16'b0, cfg_period};
                if ({12'b0, ticks_since_edge} >= target)
                begin
                    if (level)
                        shift_byte[bit_count[2:0]] = 1'b1;
                    bit_count = bit_count + 1'b1;
                    if (bit_count >= 4'd8)
                    begin
                        res.data      = shift_byte;
                        res.timed_out = 1'b0;
                        expected_rx.push_back(res);
                        rx_phase         = uartrx_pkg::PH_IDLE;
                        bit_count        = '0;
                        ticks_since_edge = '0;
                        shift_byte       = '0;
                    end
                end
            end
            default:
            begin
                rx_phase = uartrx_pkg::PH_IDLE;
                if (level)
                begin
                    rx_phase   = uartrx_pkg::PH_EDGE;
                    high_count = '0;
                end
            end
        endcase
    endfunction

    // result check first, then the line beat of the same edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                rx_count++;
                if (expected_rx.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result: data=%02h timed_out=%b", data, timed_out);
                end
                else
                begin
                    want_rx = expected_rx.pop_front();
                    if (data !== want_rx.data || timed_out !== want_rx.timed_out)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("result %0d: expected data=%02h timed_out=%b, %s%02h %s%b",
                                     rx_count, want_rx.data, want_rx.timed_out,
                                     "got data=", data, "timed_out=", timed_out);
                    end
                end
            end
            if (in_valid && in_ready)
                predict_tick(line);
        end
    end

    always @(posedge clk)
    begin
        if (hold_cycles != 0)
        begin
            hold_cycles = hold_cycles - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                ready_mode = ready_mode_e'($urandom_range(0, 3));
                mode_left  = $urandom_range(16, 160);
            end
            mode_left--;
            pattern_count <= pattern_count + 1'b1;
            case (ready_mode)
                READY_ALWAYS:  out_ready <= 1'b1;
                READY_COIN:    out_ready <= 1'($urandom_range(0, 1));
                READY_SPARSE:  out_ready <= ($urandom_range(0, 3) == 0);
                READY_PATTERN: out_ready <= (pattern_count != 3'd0);
                default:       out_ready <= 1'b1;
            endcase
        end
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    task automatic send_tick(input logic level);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, burst_max);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        line     <= level;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        ticks_sent++;
    endtask

    // start bit, eight data bits lsb first, stop bit
    task automatic send_frame(input logic [7:0] value, input int unsigned len,
                              input int unsigned lead, input bit jitter);
        int unsigned n;
        int          i;
        repeat (lead) send_tick(1'b1);
        for (i = 0; i < 10; i++)
        begin
            n = len;
            if (jitter)
                n = len + $urandom_range(0, 2) - 1;
            if (n == 0)
                n = 1;
            repeat (n) send_tick(i == 0 ? 1'b0 : (i == 9 ? 1'b1 : value[i-1]));
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_rx.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [uartrx_pkg::CFG_IDX_W-1:0] index,
                             input logic [uartrx_pkg::CFG_W-1:0] value);
        cfg_en    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_en <= 1'b0;
        if (index == uartrx_pkg::REG_BIT_PERIOD)
            cfg_period = value[uartrx_pkg::BP_W-1:0];
        else
            cfg_limit = value[uartrx_pkg::LIMIT_W-1:0];
        @(posedge clk);
    endtask

    task automatic test_reset_defaults();
        send_frame(8'($urandom), uartrx_pkg::BIT_PERIOD_RST, 3, 0);
        wait_drained();
    endtask

    task automatic test_fastest_period();
        write_reg(uartrx_pkg::REG_BIT_PERIOD, {15'h7fff, 16'd1});
        write_reg(uartrx_pkg::REG_TIMEOUT_LIMIT, uartrx_pkg::IDLE_MAX);
        send_frame(8'hff, 1, 1, 0);
        send_frame(8'h00, 1, 0, 0);
        wait_drained();
        write_reg(uartrx_pkg::REG_BIT_PERIOD, '0);
        send_frame(8'h5a, 1, 0, 0);
        wait_drained();
    endtask

    task automatic test_start_timeout();
        write_reg(uartrx_pkg::REG_BIT_PERIOD, 31'd2);
        write_reg(uartrx_pkg::REG_TIMEOUT_LIMIT, '0);
        repeat (5) send_tick(1'b1);
        send_tick(1'b0);
        wait_drained();
        // the tick that enters the edge wait is not counted
        write_reg(uartrx_pkg::REG_TIMEOUT_LIMIT, 31'd3);
        repeat (5) send_tick(1'b1);
        wait_drained();
        write_reg(uartrx_pkg::REG_TIMEOUT_LIMIT, uartrx_pkg::IDLE_MAX);
        repeat (10) send_tick(1'b1);
        wait_drained();
        write_reg(uartrx_pkg::REG_TIMEOUT_LIMIT, '0);
        repeat (2) send_tick(1'b1);
        wait_drained();
    endtask

    task automatic test_slowest_period();
        write_reg(uartrx_pkg::REG_BIT_PERIOD, 31'h0000_ffff);
        write_reg(uartrx_pkg::REG_TIMEOUT_LIMIT, 31'd12);
        repeat (30) send_tick(1'b1);
        wait_drained();
    endtask

    task automatic test_backpressure();
        write_reg(uartrx_pkg::REG_BIT_PERIOD, 31'd2);
        write_reg(uartrx_pkg::REG_TIMEOUT_LIMIT, '0);
        gap_max     = 0;
        burst_max   = 1000;
        hold_cycles = HOLD_LONG;
        repeat (120) send_tick(1'b1);
        wait_drained();
    endtask

    task automatic test_random_traffic();
        int unsigned first_tick;
        int unsigned setting_tick;
        int unsigned lead_max;
        int unsigned pick;
        logic [31:0] upper;
        logic [15:0] period;
        first_tick = ticks_sent;
        while (ticks_sent - first_tick < 850)
        begin
            wait_drained();
            upper  = $urandom;
            period = ($urandom_range(0, 5) == 0) ? 16'($urandom_range(7, 24))
                                                 : 16'($urandom_range(2, 4));
            write_reg(uartrx_pkg::REG_BIT_PERIOD, {upper[14:0], period});
            pick  = $urandom_range(0, 7);
            upper = $urandom;
            if (pick < 2)
                write_reg(uartrx_pkg::REG_TIMEOUT_LIMIT, 31'($urandom_range(0, 8)));
            else if (pick < 6)
                write_reg(uartrx_pkg::REG_TIMEOUT_LIMIT, 31'($urandom_range(9, 80)));
            else if (pick == 6)
                write_reg(uartrx_pkg::REG_TIMEOUT_LIMIT, uartrx_pkg::IDLE_MAX);
            else
                write_reg(uartrx_pkg::REG_TIMEOUT_LIMIT, {1'b1, upper[29:0]});
            gap_max   = $urandom_range(0, 4);
            burst_max = $urandom_range(1, 40);
            lead_max  = (cfg_limit < 64) ? cfg_limit + 8 : 24;
            setting_tick = ticks_sent;
            while (ticks_sent - setting_tick < 170)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 7)
                    send_frame(8'($urandom), cfg_period, $urandom_range(0, lead_max), 0);
                else if (pick < 8)
                    send_frame(8'($urandom), cfg_period, $urandom_range(0, lead_max), 1);
                else
                    repeat ($urandom_range(1, 12)) send_tick(1'($urandom_range(0, 1)));
            end
        end
        wait_drained();
    endtask

    initial
    begin
        reset_receiver_model();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_fastest_period();
        test_start_timeout();
        test_slowest_period();
        test_backpressure();
        test_random_traffic();
        while (expected_rx.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (expected_rx.size() != 0)
            errors++;
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
